### src/b32enc_pkg.sv
// shared types, constants and the character lookup for the base32 stream encoder
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package b32enc_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [6:0] PadChar   = 7'h3D;  // '='
  localparam logic [6:0] UpperBase = 7'h41;  // 'A'
  localparam logic [6:0] DigitBase = 7'h32;  // '2'
  localparam logic [4:0] NumLetters = 5'd26;

  localparam logic [2:0] FullGroup = 3'd4;   // count at which the next byte closes a group
  localparam logic [2:0] LastSlot  = 3'd7;   // eighth character of a group

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       run_last;
    logic       message_end;
  } out_beat_t;

  // one finished group waiting for the character side
  typedef struct packed {
    logic [39:0] bits;
    logic [3:0]  nch;
    logic        last;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // data characters for a group of count+1 bytes
  function automatic logic [3:0] chars_for_count(input logic [2:0] cnt);
    logic [3:0] n;
    case (cnt)
      3'd0:    n = 4'd2;
      3'd1:    n = 4'd4;
      3'd2:    n = 4'd5;
      3'd3:    n = 4'd7;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

  // 5-bit symbol to alphabet character
  function automatic logic [6:0] b32_char(input logic [4:0] sym);
    logic [6:0] c;
    if (sym < NumLetters) begin
      c = UpperBase + {2'b00, sym};
    end else begin
      c = DigitBase + {2'b00, sym - NumLetters};
    end
    return c;
  endfunction

endpackage

### src/b32enc_front.sv
// byte side of the base32 encoder: collects bytes and closes groups
// depends on b32enc_pkg
`timescale 1ns / 1ps

module b32enc_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  b32enc_pkg::in_beat_t     in_data_i,
  input  b32enc_pkg::queue_status_t q_status_i,
  output logic                     q_push_o,
  output b32enc_pkg::group_t       q_group_o
);

  logic [31:0] group_q, group_d;
  logic [2:0]  count_q, count_d;
  logic [2:0]  cnt;
  logic [39:0] merged;
  logic        closes;
  logic        accept;

  // a corrupt count is taken as four
  assign cnt = (count_q > b32enc_pkg::FullGroup) ? b32enc_pkg::FullGroup : count_q;

  always_comb begin
    case (cnt)
      3'd0:    merged = {group_q, 8'h00} | {in_data_i.data_byte, 32'h0};
      3'd1:    merged = {group_q, 8'h00} | {8'h00, in_data_i.data_byte, 24'h0};
      3'd2:    merged = {group_q, 8'h00} | {16'h0, in_data_i.data_byte, 16'h0};
      3'd3:    merged = {group_q, 8'h00} | {24'h0, in_data_i.data_byte, 8'h00};
      default: merged = {group_q, 8'h00} | {32'h0, in_data_i.data_byte};
    endcase
  end

  assign closes     = (cnt == b32enc_pkg::FullGroup) || in_data_i.is_last;
  assign in_stall_o = closes && q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  assign q_push_o       = accept && closes;
  assign q_group_o.bits = merged;
  assign q_group_o.nch  = b32enc_pkg::chars_for_count(cnt);
  assign q_group_o.last = in_data_i.is_last;

  always_comb begin
    group_d = group_q;
    count_d = count_q;
    if (accept) begin
      if (closes) begin
        group_d = 32'h0;
        count_d = 3'd0;
      end else begin
        group_d = merged[39:8];
        count_d = cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= 32'h0;
      count_q <= 3'd0;
    end else begin
      group_q <= group_d;
      count_q <= count_d;
    end
  end

endmodule

### src/b32enc_queue.sv
// short queue of finished groups between the byte side and the character side
// depends on b32enc_pkg
`timescale 1ns / 1ps

module b32enc_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  b32enc_pkg::group_t        group_i,
  input  logic                      pop_i,
  output b32enc_pkg::group_t        head_o,
  output b32enc_pkg::queue_status_t status_o
);

  b32enc_pkg::group_t entry_q [b32enc_pkg::QueueDepth];

  logic [b32enc_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [b32enc_pkg::QueueCntW-1:0] fill_q;

  localparam logic [b32enc_pkg::QueuePtrW-1:0] LastPtr =
      b32enc_pkg::QueuePtrW'(b32enc_pkg::QueueDepth - 1);
  localparam logic [b32enc_pkg::QueueCntW-1:0] FullCnt =
      b32enc_pkg::QueueCntW'(b32enc_pkg::QueueDepth);

  logic do_push, do_pop;

  assign status_o.full  = (fill_q == FullCnt);
  assign status_o.empty = (fill_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= group_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill_q <= fill_q + 1'b1;
        2'b01:   fill_q <= fill_q - 1'b1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

### src/b32enc_back.sv
// character side of the base32 encoder: walks a group one character a cycle while not stalled and a group waits
// depends on b32enc_pkg
`timescale 1ns / 1ps

module b32enc_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  b32enc_pkg::group_t        head_i,
  input  b32enc_pkg::queue_status_t q_status_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output b32enc_pkg::out_beat_t     out_data_o
);

  logic [2:0]            slot_q, slot_d;
  logic                  valid_q, valid_d;
  b32enc_pkg::out_beat_t beat_q, beat_d;
  logic                  load;
  logic                  emit;
  logic [4:0]            sym;

  assign load = !valid_q || !out_stall_i;
  assign emit = load && !q_status_i.empty;

  always_comb begin
    case (slot_q)
      3'd0:    sym = head_i.bits[39:35];
      3'd1:    sym = head_i.bits[34:30];
      3'd2:    sym = head_i.bits[29:25];
      3'd3:    sym = head_i.bits[24:20];
      3'd4:    sym = head_i.bits[19:15];
      3'd5:    sym = head_i.bits[14:10];
      3'd6:    sym = head_i.bits[9:5];
      default: sym = head_i.bits[4:0];
    endcase
  end

  always_comb begin
    slot_d  = slot_q;
    valid_d = valid_q;
    beat_d  = beat_q;
    if (emit) begin
      valid_d = 1'b1;
      slot_d  = slot_q + 3'd1;
      beat_d.out_char    = ({1'b0, slot_q} < head_i.nch) ? b32enc_pkg::b32_char(sym)
                                                         : b32enc_pkg::PadChar;
      beat_d.run_last    = (slot_q == b32enc_pkg::LastSlot);
      beat_d.message_end = (slot_q == b32enc_pkg::LastSlot) && head_i.last;
    end else if (load) begin
      valid_d = 1'b0;
    end
  end

  assign q_pop_o     = emit && (slot_q == b32enc_pkg::LastSlot);
  assign out_valid_o = valid_q;
  assign out_data_o  = beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      slot_q  <= slot_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

endmodule

### src/base32_stream_encoder.sv
// top level of the base32 stream encoder: byte side, group queue, character side
// depends on b32enc_pkg, b32enc_front, b32enc_queue and b32enc_back
`timescale 1ns / 1ps

// Base32 encoder (alphabet A-Z, 2-7, '=' padding) for a byte stream. Each input
// beat carries one message byte and an is_last flag. Bytes are gathered into
// groups of five; a full group, or the partial group closed by the last byte,
// turns into eight output beats, one character each, most significant bits
// first. A tail of 1, 2, 3 or 4 bytes gives 2, 4, 5 or 7 data characters and
// '=' up to eight. The eighth beat of every group has run_last set, and on the
// group closed by the last byte it also has message_end. Input bytes that do not
// close a group are never stalled and give no output. The character side
// puts out one beat per cycle while the output is not stalled and the queue is
// not empty. A two-deep group queue sits between the sides, so the byte side
// keeps taking beats while the character side drains; it stalls only when a byte
// closes a group and the queue is full. A closing byte is written into the
// queue, and its first character is then loaded into the output beat. The
// output beat is registered.

module base32_stream_encoder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  b32enc_pkg::in_beat_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output b32enc_pkg::out_beat_t out_data_o
);

  // group handoff between the sides
  logic                      q_push;
  logic                      q_pop;
  b32enc_pkg::group_t        q_in_group;
  b32enc_pkg::group_t        q_head;
  b32enc_pkg::queue_status_t q_status;

  // byte side: merges each byte into the group and closes it
  b32enc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .q_push_o   (q_push),
    .q_group_o  (q_in_group)
  );

  // finished groups wait here
  b32enc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .group_i  (q_in_group),
    .pop_i    (q_pop),
    .head_o   (q_head),
    .status_o (q_status)
  );

  // character side: one beat per cycle when not stalled and a group waits, pops with the eighth
  b32enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .q_status_i  (q_status),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
